[src/ahrf_pkg.sv]
package ahrf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int INC_W      = 32;
	localparam int MOD_W      = 33;
	localparam int ACC_W      = 34;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 33;

	// Small command queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// Flipping the top bit turns offset binary into two's complement.
	localparam logic [SAMPLE_W-1:0] OFFSET_BIAS = 16'h8000;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_PULL = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE    = 2'd0,
		REG_STEREO    = 2'd1,
		REG_INCREMENT = 2'd2,
		REG_MODULUS   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t                 op;
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
	} cmd_t;

	typedef struct packed {
		logic             enable;
		logic             stereo;
		logic [INC_W-1:0] increment;
		logic [MOD_W-1:0] modulus;
	} cfg_t;

endpackage

[src/ahrf_in_if.sv]
interface ahrf_in_if;
	import ahrf_pkg::*;

	logic                valid;
	logic                ready;
	logic                operation;
	logic [SAMPLE_W-1:0] left_in;
	logic [SAMPLE_W-1:0] right_in;

	modport source (output valid, output operation, output left_in, output right_in,
		input ready);
	modport sink (input valid, input operation, input left_in, input right_in,
		output ready);

endinterface

[src/ahrf_out_if.sv]
interface ahrf_out_if;
	import ahrf_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_left;
	logic signed [SAMPLE_W-1:0] out_right;
	logic                       underrun;

	modport source (output valid, output out_left, output out_right, output underrun,
		input ready);
	modport sink (input valid, input out_left, input out_right, input underrun,
		output ready);

endinterface

[src/ahrf_cfg_if.sv]
interface ahrf_cfg_if;
	import ahrf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);

endinterface

[src/audio_hold_resampler_ring_fifo_unit.sv]
// Channel  Modport  Carries                                  Handshake
// feed     sink     operation, left_in, right_in             valid/ready
// frames   source   out_left, out_right, underrun            valid/ready
// regs     sink     index, data (register write)             valid/ready, ready always high
//
// A push passes through S_ADD and then S_LOOP in the back sequencer, where the copies
// (at most RING_PAIRS) go in one by one: the ring has one write port and writes one pair a cycle.
// A pull waits in S_PULL while a result still waits on frames, then forms its result
// from the registered ring read. The front register and a four-entry command queue keep
// accepting items until the queue fills, while the back works or a result waits on frames.
// Reset clears pointers, phase and held pair; the ring itself is not cleared and needs none.
module audio_hold_resampler_ring_fifo_unit #(
	parameter int RING_PAIRS = 4096
) (
	input logic        clk,
	input logic        arst_n,
	ahrf_in_if.sink    feed,
	ahrf_out_if.source frames,
	ahrf_cfg_if.sink   regs
);
	import ahrf_pkg::*;

	cfg_t cfg_q;
	logic q_in_valid;
	logic q_in_ready;
	cmd_t q_in_cmd;
	logic q_out_valid;
	logic q_out_ready;
	cmd_t q_out_cmd;

	assign regs.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (regs.valid && regs.ready) begin
			unique case (reg_idx_t'(regs.index))
				REG_ENABLE:    cfg_q.enable    <= regs.data[0];
				REG_STEREO:    cfg_q.stereo    <= regs.data[0];
				REG_INCREMENT: cfg_q.increment <= regs.data[INC_W-1:0];
				REG_MODULUS:   cfg_q.modulus   <= regs.data[MOD_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	ahrf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.feed    (feed),
		.enable  (cfg_q.enable),
		.q_valid (q_in_valid),
		.q_ready (q_in_ready),
		.q_cmd   (q_in_cmd)
	);

	ahrf_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_in_valid),
		.wr_ready (q_in_ready),
		.wr_cmd   (q_in_cmd),
		.rd_valid (q_out_valid),
		.rd_ready (q_out_ready),
		.rd_cmd   (q_out_cmd)
	);

	ahrf_back #(
		.RING_PAIRS (RING_PAIRS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_out_valid),
		.cmd_ready (q_out_ready),
		.cmd       (q_out_cmd),
		.frames    (frames)
	);

endmodule

[src/ahrf_front.sv]
module ahrf_front (
	input  logic          clk,
	input  logic          arst_n,
	ahrf_in_if.sink       feed,
	input  logic          enable,
	output logic          q_valid,
	input  logic          q_ready,
	output ahrf_pkg::cmd_t q_cmd
);
	import ahrf_pkg::*;

	logic stg_valid_q;
	cmd_t stg_cmd_q;
	logic keep;

	// Pushes that arrive while the block is disabled are dropped here.
	assign keep       = (op_t'(feed.operation) == OP_PULL) || enable;
	assign feed.ready = !stg_valid_q || q_ready;
	assign q_valid    = stg_valid_q;
	assign q_cmd      = stg_cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_q <= 1'b0;
		end else if (feed.valid && feed.ready) begin
			stg_valid_q <= keep;
		end else if (q_ready) begin
			stg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (feed.valid && feed.ready) begin
			stg_cmd_q.op    <= op_t'(feed.operation);
			stg_cmd_q.left  <= feed.left_in;
			stg_cmd_q.right <= feed.right_in;
		end
	end

endmodule

[src/ahrf_cmd_queue.sv]
module ahrf_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  ahrf_pkg::cmd_t wr_cmd,
	output logic           rd_valid,
	input  logic           rd_ready,
	output ahrf_pkg::cmd_t rd_cmd
);
	import ahrf_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

[src/ahrf_back.sv]
module ahrf_back #(
	parameter int RING_PAIRS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ahrf_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ahrf_pkg::cmd_t cmd,
	ahrf_out_if.source     frames
);
	import ahrf_pkg::*;

	localparam int PTR_W = $clog2(RING_PAIRS);
	localparam int CNT_W = $clog2(RING_PAIRS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_LOOP,
		S_PULL
	} state_t;

	state_t                     state_q;
	logic [PTR_W-1:0]           wp_q;
	logic [PTR_W-1:0]           rp_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [ACC_W-1:0]           acc_q;
	logic [ACC_W-1:0]           work_q;
	logic [SAMPLE_W-1:0]        pair_l_q;
	logic [SAMPLE_W-1:0]        pair_r_q;
	logic [SAMPLE_W-1:0]        held_l_q;
	logic [SAMPLE_W-1:0]        held_r_q;
	logic [2*SAMPLE_W-1:0]      ring_q [RING_PAIRS];
	logic [2*SAMPLE_W-1:0]      rd_data_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_l_q;
	logic signed [SAMPLE_W-1:0] out_r_q;
	logic                       out_under_q;

	logic [ACC_W-1:0]    inc_ext;
	logic [ACC_W-1:0]    mod_ext;
	logic                below;
	logic                copy_go;
	logic [PTR_W-1:0]    wp_next;
	logic [PTR_W-1:0]    rp_next;
	logic                empty;
	logic                out_free;
	logic [SAMPLE_W-1:0] pick_l;
	logic [SAMPLE_W-1:0] pick_r;
	logic [SAMPLE_W-1:0] mix;
	logic [SAMPLE_W-1:0] res_l;
	logic [SAMPLE_W-1:0] res_r;

	assign inc_ext = {{(ACC_W-INC_W){1'b0}}, cfg.increment};
	assign mod_ext = {{(ACC_W-MOD_W){1'b0}}, cfg.modulus};
	assign below   = work_q < mod_ext;
	// One push writes at most a full ring of copies.
	assign copy_go = below && (cnt_q != CNT_W'(RING_PAIRS));
	assign wp_next = (wp_q == PTR_W'(RING_PAIRS - 1)) ? '0 : wp_q + 1'b1;
	assign rp_next = (rp_q == PTR_W'(RING_PAIRS - 1)) ? '0 : rp_q + 1'b1;
	assign empty   = (rp_q == wp_q);
	assign out_free = !out_valid_q || frames.ready;

	assign pick_l = empty ? held_l_q : rd_data_q[SAMPLE_W-1:0];
	assign pick_r = empty ? held_r_q : rd_data_q[2*SAMPLE_W-1:SAMPLE_W];
	// Each half is truncated before the sum, so it cannot carry out of 16 bits.
	assign mix    = {1'b0, pick_l[SAMPLE_W-1:1]} + {1'b0, pick_r[SAMPLE_W-1:1]};
	assign res_l  = (cfg.stereo ? pick_l : mix) ^ OFFSET_BIAS;
	assign res_r  = cfg.stereo ? (pick_r ^ OFFSET_BIAS) : '0;

	assign cmd_ready        = (state_q == S_IDLE);
	assign frames.valid     = out_valid_q;
	assign frames.out_left  = out_l_q;
	assign frames.out_right = out_r_q;
	assign frames.underrun  = out_under_q;

	// The read port follows the read pointer, which only moves in S_PULL,
	// so the data is current in S_PULL, the state a pull enters when it leaves idle.
	always_ff @(posedge clk) begin
		if (state_q == S_LOOP && copy_go) begin
			ring_q[wp_q] <= {pair_r_q, pair_l_q};
		end
		rd_data_q <= ring_q[rp_q];
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready && cmd.op == OP_PUSH) begin
			pair_l_q <= cmd.left;
			pair_r_q <= cmd.right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			cnt_q       <= '0;
			acc_q       <= '0;
			work_q      <= '0;
			held_l_q    <= '0;
			held_r_q    <= '0;
			out_valid_q <= 1'b0;
			out_l_q     <= '0;
			out_r_q     <= '0;
			out_under_q <= 1'b0;
		end else begin
			if (out_valid_q && frames.ready && !(state_q == S_PULL && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= (cmd.op == OP_PUSH) ? S_ADD : S_PULL;
					end
				end
				S_ADD: begin
					work_q  <= acc_q + inc_ext;
					cnt_q   <= '0;
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					if (copy_go) begin
						wp_q   <= wp_next;
						cnt_q  <= cnt_q + 1'b1;
						work_q <= work_q + inc_ext;
					end else begin
						// Hitting the copy cap while still below the modulus clears the phase.
						acc_q   <= below ? '0 : work_q - mod_ext;
						state_q <= S_IDLE;
					end
				end
				S_PULL: begin
					if (out_free) begin
						if (!empty) begin
							held_l_q <= rd_data_q[SAMPLE_W-1:0];
							held_r_q <= rd_data_q[2*SAMPLE_W-1:SAMPLE_W];
							rp_q     <= rp_next;
						end
						out_valid_q <= 1'b1;
						out_l_q     <= $signed(res_l);
						out_r_q     <= $signed(res_r);
						out_under_q <= empty;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q < PTR_W'(RING_PAIRS - 1) || wp_q == PTR_W'(RING_PAIRS - 1)) &&
		(rp_q < PTR_W'(RING_PAIRS - 1) || rp_q == PTR_W'(RING_PAIRS - 1)))
		else $error("ring pointer beyond the ring");

	a_copy_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOP |-> cnt_q <= CNT_W'(RING_PAIRS))
		else $error("push wrote more copies than the ring holds");

	a_pull_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PULL && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("pull finished without a result");

	a_underrun_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PULL && out_free && empty) |=> $stable(rp_q))
		else $error("read pointer moved on an underrun");

endmodule
